// ===== src/utf8_to_utf16_transcoder_defines.svh =====
// Assertion helpers for the UTF-8 to UTF-16 transcoder.
// The enclosing module must provide clk_i and rst_ni.
`ifndef UTF8_TO_UTF16_TRANSCODER_DEFINES_SVH
`define UTF8_TO_UTF16_TRANSCODER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define U8U16_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("u8u16: same-cycle check failed");

// Next-cycle implication
`define U8U16_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("u8u16: next-cycle check failed");

`else

`define U8U16_ASSERT_IMP(lbl, ante, cons)
`define U8U16_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ===== src/u8u16_pkg.sv =====
package u8u16_pkg;

  // Code point limits and surrogate bases
  localparam logic [20:0] CpSurrMin  = 21'h10000;
  localparam logic [15:0] SurrHiBase = 16'hD800;
  localparam logic [15:0] SurrLoBase = 16'hDC00;
  localparam logic [9:0]  SurrLoMask = 10'h3FF;
  localparam logic [5:0]  ContMask   = 6'h3F;
  localparam logic [4:0]  Lead4Tag   = 5'h1E;

  localparam int unsigned MaxUnits = 3;

  // Open-sequence bookkeeping
  typedef struct packed {
    logic [7:0] lead;    // lead byte of the open sequence
    logic [1:0] needed;  // continuation bytes still to come in total, 0 = idle
    logic [1:0] held;    // continuation bytes collected so far
  } ctl_t;

  // Up to three code units produced by one byte
  typedef struct packed {
    logic [MaxUnits-1:0][15:0] units;
    logic [1:0]                cnt;
    logic                      term;  // last unit is the zero terminator
  } res_t;

  // Sequence length announced by a byte: 1 ASCII, 2..4 lead, 0 otherwise
  function automatic logic [2:0] seq_len(input logic [7:0] c);
    logic [2:0] len;
    if (c[7] == 1'b0) begin
      len = 3'd1;
    end else if (c[7:5] == 3'b110) begin
      len = 3'd2;
    end else if (c[7:4] == 4'b1110) begin
      len = 3'd3;
    end else if (c[7:3] == Lead4Tag) begin
      len = 3'd4;
    end else begin
      len = 3'd0;
    end
    return len;
  endfunction

endpackage

// ===== src/u8u16_if.sv =====
// Byte request channel
interface u8u16_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       stream_last;

  modport source (output valid, output data_byte, output stream_last, input ready);
  modport sink   (input valid, input data_byte, input stream_last, output ready);
endinterface

// Code unit request channel
interface u8u16_unit_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        run_last;
  logic        terminator;

  modport source (output valid, output code_unit, output run_last, output terminator,
                  input ready);
  modport sink   (input valid, input code_unit, input run_last, input terminator,
                  output ready);
endinterface

// ===== src/utf8_to_utf16_transcoder.sv =====
// UTF-8 to UTF-16 transcoder. Takes one UTF-8 byte per request on byte_i and
// gives UTF-16 code units on unit_o, a surrogate pair high half first, and a
// zero terminator after the byte flagged stream_last. A byte is taken in every
// cycle as long as the bytes give at most one unit each and the receiver takes
// each unit; a byte that gives several units holds the result register until its
// last unit is taken, since that register hands out one unit per cycle while ready
// is high. Bytes that give no unit (leads, continuation bytes, stray bytes) pass
// through and do not use the result register. A byte goes first into the input
// register and then, once the result register is free, into the result register,
// which offers its first unit. run_last flags the last unit that a byte causes.
`include "utf8_to_utf16_transcoder_defines.svh"

module utf8_to_utf16_transcoder (
  input logic         clk_i,
  input logic         rst_ni,
  u8u16_byte_if.sink   byte_i,
  u8u16_unit_if.source unit_o
);
  import u8u16_pkg::*;

  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  ctl_t       ctl_q;
  ctl_t       ctl_d;
  logic [7:0] hold_q [2];
  logic       hold_we;
  logic       hold_idx;
  res_t       dec_res;
  res_t       res_q;
  logic       res_vld_q;
  logic [1:0] pos_q;

  logic in_fire;
  logic in_adv;
  logic out_fire;
  logic unit_last;
  logic res_free;

  // Decoder between input register and result register
  u8u16_decode u_decode (
    .data_byte_i   (in_byte_q),
    .stream_last_i (in_last_q),
    .ctl_i         (ctl_q),
    .hold0_i       (hold_q[0]),
    .hold1_i       (hold_q[1]),
    .ctl_o         (ctl_d),
    .hold_we_o     (hold_we),
    .hold_idx_o    (hold_idx),
    .res_o         (dec_res)
  );

  // Handshake and flow control
  assign out_fire  = res_vld_q && unit_o.ready;
  assign unit_last = (pos_q == (res_q.cnt - 2'd1));
  assign res_free  = !res_vld_q || (out_fire && unit_last);
  assign in_adv    = in_vld_q && ((dec_res.cnt == 2'd0) || res_free);
  assign in_fire   = byte_i.valid && byte_i.ready;

  assign byte_i.ready = !in_vld_q || in_adv;

  // Output drive
  assign unit_o.valid      = res_vld_q;
  assign unit_o.code_unit  = res_q.units[pos_q];
  assign unit_o.run_last   = unit_last;
  assign unit_o.terminator = res_q.term && unit_last;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      ctl_q     <= '0;
      res_vld_q <= 1'b0;
      pos_q     <= 2'd0;
    end else begin
      if (in_fire) begin
        in_vld_q <= 1'b1;
      end else if (in_adv) begin
        in_vld_q <= 1'b0;
      end

      if (in_adv) begin
        ctl_q <= ctl_d;
      end

      if (in_adv && (dec_res.cnt != 2'd0)) begin
        res_vld_q <= 1'b1;
        pos_q     <= 2'd0;
      end else if (out_fire) begin
        if (unit_last) begin
          res_vld_q <= 1'b0;
        end else begin
          pos_q <= pos_q + 2'd1;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_byte_q <= byte_i.data_byte;
      in_last_q <= byte_i.stream_last;
    end
    if (in_adv && hold_we) begin
      hold_q[hold_idx] <= in_byte_q;
    end
    if (in_adv && (dec_res.cnt != 2'd0)) begin
      res_q <= dec_res;
    end
  end

  // Checks
  `U8U16_ASSERT_IMP(a_pos_in_range, res_vld_q, pos_q < res_q.cnt)
  `U8U16_ASSERT_IMP(a_held_below_needed, ctl_q.needed != 2'd0, ctl_q.held < ctl_q.needed)
  `U8U16_ASSERT_IMP(a_idle_nothing_held, ctl_q.needed == 2'd0, ctl_q.held == 2'd0)
  `U8U16_ASSERT_NXT(a_last_closes, in_adv && in_last_q, ctl_q.needed == 2'd0)

endmodule

// ===== src/u8u16_decode.sv =====
// Decodes one byte against the open-sequence state into up to three code units
module u8u16_decode (
  input  logic [7:0]      data_byte_i,
  input  logic            stream_last_i,
  input  u8u16_pkg::ctl_t ctl_i,
  input  logic [7:0]      hold0_i,
  input  logic [7:0]      hold1_i,
  output u8u16_pkg::ctl_t ctl_o,
  output logic            hold_we_o,
  output logic            hold_idx_o,
  output u8u16_pkg::res_t res_o
);
  import u8u16_pkg::*;

  logic [2:0]  len_c;
  logic [2:0]  len_h0;
  logic        complete;
  logic [20:0] cp_full;
  logic [20:0] cp_off;

  assign len_c    = seq_len(data_byte_i);
  assign len_h0   = seq_len(hold0_i);
  assign complete = (ctl_i.needed != 2'd0) &&
                    (({1'b0, ctl_i.held} + 3'd1) >= {1'b0, ctl_i.needed});

  // Assemble the code point of a full sequence
  always_comb begin
    case (ctl_i.needed)
      2'd1:    cp_full = {10'd0, ctl_i.lead[4:0], data_byte_i[5:0] & ContMask};
      2'd2:    cp_full = {5'd0, ctl_i.lead[3:0], hold0_i[5:0] & ContMask,
                          data_byte_i[5:0] & ContMask};
      default: cp_full = {ctl_i.lead[2:0], hold0_i[5:0] & ContMask,
                          hold1_i[5:0] & ContMask, data_byte_i[5:0] & ContMask};
    endcase
  end

  assign cp_off = cp_full - CpSurrMin;

  // Build the unit list and the next state
  always_comb begin
    logic [1:0] n;
    logic       tail_h0;
    n          = 2'd0;
    res_o      = '0;
    ctl_o      = ctl_i;
    hold_we_o  = 1'b0;
    hold_idx_o = ctl_i.held[0];
    tail_h0    = (ctl_i.needed != 2'd0) && (ctl_i.held == 2'd1);

    if (complete) begin
      if (cp_full >= CpSurrMin) begin
        res_o.units[n] = SurrHiBase + {5'd0, cp_off[20:10]};
        n              = n + 2'd1;
        res_o.units[n] = SurrLoBase + {6'd0, cp_off[9:0] & SurrLoMask};
        n              = n + 2'd1;
      end else begin
        res_o.units[n] = cp_full[15:0];
        n              = n + 2'd1;
      end
      ctl_o = '0;
    end else if (stream_last_i) begin
      // unfinished sequence: lead dropped, collected bytes decoded again
      if (tail_h0 && (len_h0 == 3'd2)) begin
        res_o.units[n] = {5'd0, hold0_i[4:0], data_byte_i[5:0] & ContMask};
        n              = n + 2'd1;
      end else begin
        if (tail_h0 && (len_h0 == 3'd1)) begin
          res_o.units[n] = {8'd0, hold0_i};
          n              = n + 2'd1;
        end
        if (len_c == 3'd1) begin
          res_o.units[n] = {8'd0, data_byte_i};
          n              = n + 2'd1;
        end
      end
    end else if (ctl_i.needed == 2'd0) begin
      if (len_c == 3'd1) begin
        res_o.units[n] = {8'd0, data_byte_i};
        n              = n + 2'd1;
      end else if (len_c >= 3'd2) begin
        ctl_o.lead   = data_byte_i;
        ctl_o.needed = 2'(len_c - 3'd1);
        ctl_o.held   = 2'd0;
      end
    end else begin
      hold_we_o  = 1'b1;
      ctl_o.held = ctl_i.held + 2'd1;
    end

    // zero terminator closes the string
    if (stream_last_i) begin
      res_o.units[n] = 16'd0;
      n              = n + 2'd1;
      res_o.term     = 1'b1;
      ctl_o          = '0;
    end

    res_o.cnt = n;
  end

endmodule

// ===== tb/utf8_to_utf16_transcoder_tb.sv =====
module utf8_to_utf16_transcoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import u8u16_pkg::*;

  localparam int RandomBytes = 230;
  localparam int StallLimit  = 2000;
  localparam int HoldCycles  = 300;
  localparam int DrainCycles = 8;

  // One code unit as it leaves the block
  typedef struct packed {
    logic [15:0] code_unit;
    logic        run_last;
    logic        terminator;
  } unit_t;

  // Tracks the decoder state and the code units still owed by the block
  class utf16_scoreboard;
    logic [7:0] lead;
    logic [1:0] needed;
    logic [1:0] held;
    logic [7:0] cont [3];
    unit_t      step_units [$];
    unit_t      expected_units [$];
    int         mismatches;

    function new();
      lead       = '0;
      needed     = '0;
      held       = '0;
      mismatches = 0;
    endfunction

    // Bytes in the sequence a byte opens; 0 when it cannot open one
    function int unsigned span(logic [7:0] c);
      casez (c)
        8'b0???????: return 1;
        8'b110?????: return 2;
        8'b1110????: return 3;
        8'b11110???: return 4;
        default:     return 0;
      endcase
    endfunction

    function logic [20:0] code_point(logic [7:0] seq [4], int unsigned first, int unsigned n);
      logic [20:0] cp;
      case (n)
        2: cp = {10'd0, seq[first][4:0], seq[first+1][5:0]};
        3: cp = {5'd0, seq[first][3:0], seq[first+1][5:0], seq[first+2][5:0]};
        4: cp = {seq[first][2:0], seq[first+1][5:0], seq[first+2][5:0], seq[first+3][5:0]};
        default: cp = {13'd0, seq[first]};
      endcase
      return cp;
    endfunction

    function void add_unit(logic [15:0] u, logic term);
      unit_t x;
      x = '{u, 1'b0, term};
      step_units.insert(step_units.size(), x);
    endfunction

    // Supplementary planes split into a surrogate pair, high half first
    function void add_cp(logic [20:0] cp);
      logic [20:0] v;
      if (cp >= CpSurrMin) begin
        v = cp - CpSurrMin;
        add_unit(SurrHiBase + 16'(v >> 10), 1'b0);
        add_unit(SurrLoBase + {6'd0, v[9:0]}, 1'b0);
      end else begin
        add_unit(cp[15:0], 1'b0);
      end
    endfunction

    // Lead, collected bytes and the new byte, in stream order
    function int unsigned gather(output logic [7:0] seq [4], input logic [7:0] b);
      int unsigned n;
      seq[0] = lead;
      n = 1;
      for (int k = 0; k < held && k < 2; k++) begin
        seq[n] = cont[k];
        n++;
      end
      seq[n] = b;
      n++;
      return n;
    endfunction

    // Redecode a closed tail, skipping leads that cannot complete
    function void decode_tail(logic [7:0] seq [4], int unsigned n);
      int unsigned i;
      int unsigned l;
      i = 0;
      while (i < n) begin
        l = span(seq[i]);
        if (l == 0 || i + l > n) begin
          i++;
        end else begin
          add_cp(code_point(seq, i, l));
          i += l;
        end
      end
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      logic [7:0]  seq [4];
      int unsigned n;
      int unsigned l;
      step_units.delete();
      if (last) begin
        if (needed != 0) begin
          n = gather(seq, b);
        end else begin
          seq[0] = b;
          n = 1;
        end
        decode_tail(seq, n);
        add_unit(16'h0000, 1'b1);
        needed = '0;
        held   = '0;
        lead   = '0;
      end else if (needed == 0) begin
        l = span(b);
        if (l == 1) begin
          add_unit({8'd0, b}, 1'b0);
        end else if (l >= 2) begin
          lead   = b;
          needed = 2'(l - 1);
          held   = '0;
        end
      end else if (held + 1 >= needed) begin
        n = gather(seq, b);
        add_cp(code_point(seq, 0, n));
        needed = '0;
        held   = '0;
        lead   = '0;
      end else begin
        cont[held] = b;
        held++;
      end
      if (step_units.size() > 0) begin
        step_units[step_units.size()-1].run_last = 1'b1;
      end
      foreach (step_units[i]) expected_units.insert(expected_units.size(), step_units[i]);
    endfunction

    function void check_unit(logic [15:0] code, logic rl, logic term);
      unit_t got;
      unit_t want;
      got = '{code, rl, term};
      if (expected_units.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: unexpected unit %h run_last %b terminator %b", $realtime, code, rl, term);
        end
      end else begin
        want = expected_units.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: code_unit exp %h got %h, run_last exp %b got %b, terminator exp %b got %b",
                     $realtime, want.code_unit, code, want.run_last, rl, want.terminator, term);
          end
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  u8u16_byte_if byte_bus ();
  u8u16_unit_if unit_bus ();

  utf8_to_utf16_transcoder u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (byte_bus),
    .unit_o (unit_bus)
  );

  utf16_scoreboard sb;

  int bytes_sent  = 0;
  int burst_left  = 0;
  int hold_left   = 0;
  int idle_cycles = 0;
  int ready_run   = 0;
  bit ready_level = 1'b0;

  // Bit 8 flags the last byte of a string
  logic [8:0] directed_bytes [$] = '{
    9'h000,                          // zero byte, not a terminator
    9'h0C3, 9'h0A9,                  // two-byte sequence
    9'h0E2, 9'h082, 9'h0AC,          // three-byte sequence
    9'h0F0, 9'h09F, 9'h098, 9'h080,  // surrogate pair
    9'h080, 9'h0F8, 9'h0FF,          // stray bytes
    9'h0C0, 9'h0E2,                  // overlong lead, lead byte taken as continuation
    9'h0C3, 9'h041,                  // ASCII taken as continuation
    9'h0E2, 9'h141,                  // unfinished sequence at stream end
    9'h1C3,                          // lead as the last byte
    9'h0F7, 9'h0BF, 9'h0BF, 9'h1BF,  // top code point completed by the last byte
    9'h17F                           // ASCII as the last byte
  };

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Sender gap: mostly none or short, now and then long, with bursts
  function automatic int pick_gap();
    int r;
    if (hold_left != 0) return 0;
    if (burst_left != 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      burst_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      byte_bus.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    byte_bus.valid       <= 1'b1;
    byte_bus.data_byte   <= b;
    byte_bus.stream_last <= last;
    do @(posedge clk_i); while (!byte_bus.ready);
    sb.note_byte(b, last);
    bytes_sent++;
  endtask

  // A string of mostly well-formed characters, some noise and cut sequences
  task automatic send_random_string();
    logic [7:0] text [$];
    int chars;
    int len;
    int r;
    int n;
    chars = $urandom_range(1, 12);
    repeat (chars) begin
      r   = $urandom_range(0, 99);
      len = $urandom_range(1, 4);
      if (r < 10) begin
        text.insert(text.size(), 8'($urandom));
      end else begin
        case (len)
          1:       text.insert(text.size(), {1'b0, 7'($urandom)});
          2:       text.insert(text.size(), {3'b110, 5'($urandom)});
          3:       text.insert(text.size(), {4'b1110, 4'($urandom)});
          default: text.insert(text.size(), {5'b11110, 3'($urandom)});
        endcase
        n = (r < 18) ? $urandom_range(0, len - 1) : len - 1;
        repeat (n) text.insert(text.size(), (r < 14) ? 8'($urandom) : {2'b10, 6'($urandom)});
      end
    end
    foreach (text[i]) send_byte(text[i], i == text.size() - 1);
  endtask

  // Receiver: alternating ready runs, plus one long hold-off on request
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      unit_bus.ready <= 1'b0;
    end else if (hold_left != 0) begin
      unit_bus.ready <= 1'b0;
      hold_left--;
    end else begin
      if (ready_run == 0) begin
        ready_level = !ready_level;
        if (ready_level) begin
          ready_run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
        end else begin
          ready_run = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
        end
      end
      unit_bus.ready <= ready_level;
      ready_run--;
    end
  end

  // Check every accepted unit request
  always @(posedge clk_i) begin
    if (rst_ni && unit_bus.valid && unit_bus.ready) begin
      sb.check_unit(unit_bus.code_unit, unit_bus.run_last, unit_bus.terminator);
    end
  end

  // Watchdog on cycles with no request moving on either side
  always @(posedge clk_i) begin
    if ((byte_bus.valid && byte_bus.ready) || (unit_bus.valid && unit_bus.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= StallLimit);
    $display("** utf8_to_utf16_transcoder: FAILED **");
    $finish;
  end

  initial begin
    bit held_off;
    held_off = 1'b0;
    sb = new();
    byte_bus.valid       = 1'b0;
    byte_bus.data_byte   = '0;
    byte_bus.stream_last = 1'b0;
    unit_bus.ready       = 1'b0;
    rst_ni               = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_bytes[i]) send_byte(directed_bytes[i][7:0], directed_bytes[i][8]);

    while (bytes_sent < directed_bytes.size() + RandomBytes) begin
      // Once, stall the receiver long enough for the block to back up
      if (!held_off && bytes_sent >= directed_bytes.size() + 80) begin
        hold_left = HoldCycles;
        held_off  = 1'b1;
      end
      send_random_string();
    end
    @(negedge clk_i);
    byte_bus.valid <= 1'b0;

    while (sb.expected_units.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("** utf8_to_utf16_transcoder: PASSED **");
    end else begin
      $display("** utf8_to_utf16_transcoder: FAILED **");
    end
    $finish;
  end

endmodule
